// File: rtl/core/catan_pkg.sv
// ----------------------------------------------------------------------------
// catan_pkg
// Shared types and constants for the pipelined degree-output arc tangent.
// ----------------------------------------------------------------------------
package catan_pkg;

    // Widths of the rotation vector, the angle accumulator, the inputs, the output angle and the products.
    localparam int unsigned XY_W  = 16;
    localparam int unsigned Z_W   = 14;
    localparam int unsigned IN_W  = 16;
    localparam int unsigned OUT_W = 15;
    localparam int unsigned PROD_W = 32;

    // Deepest rotation the angle table supports.
    localparam int unsigned MAX_STEPS = 10;

    // Angles in 1/64 degree.
    localparam logic signed [Z_W-1:0] QUARTER_TURN = 14'sd5760;
    localparam logic signed [15:0]    HALF_TURN    = 16'sd11520;
    localparam logic signed [15:0]    FULL_TURN    = 16'sd23040;

    // Start vector of the rotation in Q13.
    localparam logic signed [XY_W-1:0] X_START = 16'sd8192;

    // Largest positive input value, used when negating saturates.
    localparam logic signed [IN_W-1:0] IN_MAX = 16'sd32767;

    // Rotation angle of each step, atan(2^-i) in 1/64 degree.
    localparam logic signed [Z_W-1:0] STEP_ANGLE [MAX_STEPS] = '{
        14'sd2880, 14'sd1700, 14'sd898, 14'sd456, 14'sd229,
        14'sd115,  14'sd57,   14'sd29,  14'sd14,  14'sd7
    };

    // One request as it travels down the rotation pipeline.
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic signed [IN_W-1:0] a;     // folded denominator, never negative
        logic signed [IN_W-1:0] b;     // folded numerator
        logic                   neg;   // original denominator was negative
        logic                   spec;  // answer already known, rotation frozen
    } catan_item_t;

endpackage

// File: rtl/core/catan_prep.sv
// ----------------------------------------------------------------------------
// catan_prep
// Input register: folds the left half plane onto the right half and
// resolves the axis cases before the rotation starts.
// ----------------------------------------------------------------------------
module catan_prep (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 valid_in,
    input  logic signed [catan_pkg::IN_W-1:0]    numerator,
    input  logic signed [catan_pkg::IN_W-1:0]    denominator,
    output logic                                 valid_out,
    output catan_pkg::catan_item_t               item_out
);
    import catan_pkg::*;

    logic                   valid_reg;
    catan_item_t            item_reg;
    catan_item_t            item_next;
    logic signed [IN_W-1:0] a_fold;
    logic signed [IN_W-1:0] b_fold;

    // Negation with the most negative code clamped to the largest positive.
    function automatic logic signed [IN_W-1:0] sat_neg(input logic signed [IN_W-1:0] v);
        logic signed [IN_W-1:0] r;
        if (v == {1'b1, {(IN_W-1){1'b0}}})
        begin
            r = IN_MAX;
        end
        else
        begin
            r = -v;
        end
        return r;
    endfunction

    // Fold, then set up the start vector or the known answer.
    always_comb
    begin
        a_fold = denominator[IN_W-1] ? sat_neg(denominator) : denominator;
        b_fold = denominator[IN_W-1] ? sat_neg(numerator)   : numerator;

        item_next.x    = X_START;
        item_next.y    = '0;
        item_next.a    = a_fold;
        item_next.b    = b_fold;
        item_next.neg  = denominator[IN_W-1];
        item_next.spec = (a_fold == '0) || (b_fold == '0);
        item_next.z    = '0;
        if (a_fold == '0 && b_fold != '0)
        begin
            item_next.z = b_fold[IN_W-1] ? -QUARTER_TURN : QUARTER_TURN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign valid_out = valid_reg;
    assign item_out  = item_reg;

endmodule

// File: rtl/core/catan_step.sv
// ----------------------------------------------------------------------------
// catan_step
// One rotation step in two stages: the cross products y*a and x*b are
// registered first, then comparing them decides the direction of the turn.
// ----------------------------------------------------------------------------
module catan_step #(
    parameter int unsigned STEP = 0
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    valid_in,
    input  catan_pkg::catan_item_t  item_in,
    output logic                    valid_out,
    output catan_pkg::catan_item_t  item_out
);
    import catan_pkg::*;

    logic                     mul_valid_reg;
    catan_item_t              mul_item_reg;
    logic signed [PROD_W-1:0] ya_reg;
    logic signed [PROD_W-1:0] xb_reg;
    logic signed [PROD_W-1:0] ya_next;
    logic signed [PROD_W-1:0] xb_next;

    logic                     rot_valid_reg;
    catan_item_t              rot_item_reg;
    catan_item_t              rot_item_next;
    logic signed [XY_W-1:0]   x_sh;
    logic signed [XY_W-1:0]   y_sh;
    logic                     turn_down;

    // Stage one: cross products of the current vector with the target.
    always_comb
    begin
        ya_next = PROD_W'(item_in.y) * PROD_W'(item_in.a);
        xb_next = PROD_W'(item_in.x) * PROD_W'(item_in.b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            rot_valid_reg <= 1'b0;
        end
        else
        begin
            mul_valid_reg <= valid_in;
            rot_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mul_item_reg <= item_in;
        ya_reg       <= ya_next;
        xb_reg       <= xb_next;
    end

    // Stage two: turn away from the side the vector has overshot.
    always_comb
    begin
        x_sh          = mul_item_reg.x >>> STEP;
        y_sh          = mul_item_reg.y >>> STEP;
        turn_down     = ya_reg > xb_reg;
        rot_item_next = mul_item_reg;
        if (!mul_item_reg.spec)
        begin
            if (turn_down)
            begin
                rot_item_next.x = mul_item_reg.x + y_sh;
                rot_item_next.y = mul_item_reg.y - x_sh;
                rot_item_next.z = mul_item_reg.z - STEP_ANGLE[STEP];
            end
            else
            begin
                rot_item_next.x = mul_item_reg.x - y_sh;
                rot_item_next.y = mul_item_reg.y + x_sh;
                rot_item_next.z = mul_item_reg.z + STEP_ANGLE[STEP];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rot_item_reg <= rot_item_next;
    end

    assign valid_out = rot_valid_reg;
    assign item_out  = rot_item_reg;

endmodule

// File: rtl/core/catan_post.sv
// ----------------------------------------------------------------------------
// catan_post
// Output register: unfolds left half plane results by a half turn and
// wraps them back into the open-closed range around zero.
// ----------------------------------------------------------------------------
module catan_post (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 valid_in,
    input  catan_pkg::catan_item_t               item_in,
    output logic                                 done,
    output logic signed [catan_pkg::OUT_W-1:0]   angle
);
    import catan_pkg::*;

    logic                    done_reg;
    logic signed [OUT_W-1:0] angle_reg;
    logic signed [OUT_W-1:0] angle_next;
    logic signed [15:0]      z_wide;
    logic signed [15:0]      shifted;

    // Subtract a half turn for the left half plane and wrap once.
    always_comb
    begin
        z_wide  = 16'(item_in.z);
        shifted = z_wide - HALF_TURN;
        if (shifted <= -HALF_TURN)
        begin
            shifted = shifted + FULL_TURN;
        end
        angle_next = item_in.neg ? shifted[OUT_W-1:0] : z_wide[OUT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        angle_reg <= angle_next;
    end

    assign done  = done_reg;
    assign angle = angle_reg;

endmodule

// File: rtl/core/cordic_atan2_degrees.sv
// ----------------------------------------------------------------------------
// cordic_atan2_degrees
// Four-quadrant arc tangent of numerator over denominator in 1/64 degree.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on every rising edge where start is high and busy is
//   low. numerator and denominator are signed Q6.10 values. busy is always
//   low, so a new request may be issued in every cycle.
//   The result appears on angle for exactly one cycle, flagged by done,
//   after the request has passed one input register, two stages per
//   rotation step (cross products, then the turn) and one output
//   register. Throughput is one request per cycle.
//   angle is signed 1/64 degree in (-11520, 11520]; a zero vector gives 0.
//   Results leave in request order. The receiver must take done/angle in the
//   cycle they are shown; there is no hold-off.
//   Reset (rst_n low) clears every valid bit, so requests in flight are
//   dropped and no done pulse follows.
// ----------------------------------------------------------------------------
module cordic_atan2_degrees #(
    parameter int unsigned ITERATIONS = 10
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [catan_pkg::IN_W-1:0]    numerator,
    input  logic signed [catan_pkg::IN_W-1:0]    denominator,
    output logic                                 done,
    output logic signed [catan_pkg::OUT_W-1:0]   angle
);
    import catan_pkg::*;

    logic        stage_valid [ITERATIONS+1];
    catan_item_t stage_item  [ITERATIONS+1];
    logic        accept;

    // The pipeline never stalls.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Folding and axis cases.
    catan_prep u_prep (
        .clk         (clk),
        .rst_n       (rst_n),
        .valid_in    (accept),
        .numerator   (numerator),
        .denominator (denominator),
        .valid_out   (stage_valid[0]),
        .item_out    (stage_item[0])
    );

    // Chain of rotation steps.
    for (genvar i = 0; i < ITERATIONS; i++)
    begin : g_step
        catan_step #(
            .STEP (i)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (stage_valid[i]),
            .item_in   (stage_item[i]),
            .valid_out (stage_valid[i+1]),
            .item_out  (stage_item[i+1])
        );
    end

    // Unfolding and result register.
    catan_post u_post (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid_in (stage_valid[ITERATIONS]),
        .item_in  (stage_item[ITERATIONS]),
        .done     (done),
        .angle    (angle)
    );

    // The lower end of the range never appears.
    a_no_low_end: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (angle != -15'sd11520))
        else $error("angle at excluded lower end");

    // Results never exceed a half turn.
    a_upper: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (angle <= 15'sd11520))
        else $error("angle above half turn");

    // After folding, the denominator is never negative.
    a_fold_pos: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid[0] |-> !stage_item[0].a[IN_W-1])
        else $error("folded denominator negative");

    // A request that still rotates has nonzero components on both axes.
    a_rot_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid[0] && !stage_item[0].spec) |->
            (stage_item[0].a != '0 && stage_item[0].b != '0))
        else $error("rotation started on an axis case");

endmodule
